@@ hdl/tpmf_pkg.sv @@
// ----------------------------------------------------------------------------
// Tilt pointer motion filter package
// Shared types and constants for the tilt pointer motion filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tpmf_pkg;

  localparam int unsigned AngleW  = 17;
  localparam int unsigned SmoothW = 24;
  localparam int unsigned MulAW   = 25;
  localparam int unsigned MulBW   = 18;
  localparam int unsigned ProdW   = MulAW + MulBW;
  localparam int unsigned AddrW   = 5;
  localparam int unsigned DataW   = 32;

  // Register indexes on the configuration port (word address).
  localparam logic [2:0] RegDeadZone   = 3'd0;
  localparam logic [2:0] RegGain       = 3'd1;
  localparam logic [2:0] RegMaxSpeed   = 3'd2;
  localparam logic [2:0] RegSmoothing  = 3'd3;
  localparam logic [2:0] RegThreshold  = 3'd4;

  localparam logic [15:0] DeadZoneRst  = 16'd1280;
  localparam logic [15:0] GainRst      = 16'd1229;
  localparam logic [6:0]  MaxSpeedRst  = 7'd20;
  localparam logic [15:0] SmoothingRst = 16'd60293;
  localparam logic [14:0] ThresholdRst = 15'd128;

  typedef logic signed [AngleW-1:0]  angle_t;
  typedef logic signed [SmoothW-1:0] smooth_t;
  typedef logic signed [ProdW-1:0]   prod_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RAW_X,
    ST_RAW_Y,
    ST_OLD_X,
    ST_NEW_X,
    ST_OLD_Y,
    ST_NEW_Y,
    ST_ACC_Y,
    ST_FIN_Y,
    ST_OUT
  } state_t;

endpackage

@@ hdl/tilt_pointer_motion_filter.sv @@
// ----------------------------------------------------------------------------
// Tilt pointer motion filter
// Dead zone, gain, clamp and exponential smoothing of two tilt angles, plus
// button edge detection and scroll mode, one result per frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Each request runs, from the accepting edge to a loaded result, through
// eight steps on the single shared 25 x 18 bit multiplier and its
// accumulator (two gain products, four smoothing products, and their sums),
// and a final step that forms the result. in_ready is high only while the
// sequencer is idle, so a new request is taken in only once the last one's
// result is loaded; a result that is not taken holds this up. A finished
// result waits in the output register while the next request is taken in.
// Configuration registers are written through the APB port and
// must only change while the block is idle.
module tilt_pointer_motion_filter (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  tpmf_pkg::angle_t            angle_x,
  input  tpmf_pkg::angle_t            angle_y,
  input  logic                        left_level,
  input  logic                        right_level,
  input  logic                        scroll_level,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        move_valid,
  output logic signed [7:0]           move_x,
  output logic signed [7:0]           move_y,
  output logic                        left_click,
  output logic                        right_click,
  output logic                        scroll_valid,
  output logic signed [2:0]           scroll_amount,
  output logic                        scroll_mode_on,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tpmf_pkg::AddrW-1:0]  paddr,
  input  logic [tpmf_pkg::DataW-1:0]  pwdata,
  output logic [tpmf_pkg::DataW-1:0]  prdata,
  output logic                        pready
);

  import tpmf_pkg::*;

  // Configuration registers
  logic [15:0] zone_half;
  logic [15:0] gain;
  logic [6:0]  speed_limit;
  logic [15:0] smoothing;
  logic [14:0] move_threshold;

  // Filter state
  smooth_t smooth_x;
  smooth_t smooth_y;
  logic    last_left;
  logic    last_right;
  logic    last_scroll;
  logic    scroll_mode;

  state_t state;
  state_t state_next;

  // Per-request working registers
  logic [AngleW-1:0] exc_x;
  logic [AngleW-1:0] exc_y;
  logic              neg_x;
  logic              neg_y;
  smooth_t           raw_x;
  smooth_t           raw_y;
  prod_t             prod;
  prod_t             acc;
  logic              hold_left;
  logic              hold_right;
  logic              hold_scv;
  logic signed [2:0] hold_sa;

  // Sequencer controls
  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic                    load_raw_x;
  logic                    load_raw_y;
  logic                    acc_load;
  logic                    acc_add;
  logic                    load_sx;
  logic                    load_sy;
  logic                    out_load;

  logic                    accept;
  logic                    cfg_write;
  logic signed [MulBW-1:0] weight_new;

  // Input decode
  logic [AngleW-1:0] mag_ax;
  logic [AngleW-1:0] mag_ay;
  logic              mode_new;
  logic [1:0]        steps;

  // Clamp of the gain product
  logic [28:0] prod_shr;
  logic [28:0] lim;
  logic [22:0] raw_mag;
  smooth_t     raw_pos;
  smooth_t     acc_trunc;

  // Result formation
  logic [SmoothW-1:0] abs_sx;
  logic [SmoothW-1:0] abs_sy;
  logic [SmoothW-1:0] thr;
  logic               mv;
  logic [7:0]         mag_mx;
  logic [7:0]         mag_my;

  function automatic smooth_t trunc16(input prod_t v);
    prod_t b;
    b = v + (v[ProdW-1] ? prod_t'(65535) : prod_t'(0));
    return b[SmoothW+15:16];
  endfunction

  assign accept    = in_valid && in_ready;
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  // ---------------- Configuration port ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      zone_half      <= DeadZoneRst;
      gain           <= GainRst;
      speed_limit    <= MaxSpeedRst;
      smoothing      <= SmoothingRst;
      move_threshold <= ThresholdRst;
    end else if (cfg_write) begin
      unique case (paddr[4:2])
        RegDeadZone:  zone_half      <= pwdata[15:0];
        RegGain:      gain           <= pwdata[15:0];
        RegMaxSpeed:  speed_limit    <= pwdata[6:0];
        RegSmoothing: smoothing      <= pwdata[15:0];
        RegThreshold: move_threshold <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      RegDeadZone:  prdata = {16'd0, zone_half};
      RegGain:      prdata = {16'd0, gain};
      RegMaxSpeed:  prdata = {25'd0, speed_limit};
      RegSmoothing: prdata = {16'd0, smoothing};
      RegThreshold: prdata = {17'd0, move_threshold};
      default:      prdata = '0;
    endcase
  end

  // ---------------- Input decode ----------------
  assign mag_ax   = angle_x[AngleW-1] ? AngleW'(-angle_x) : AngleW'(angle_x);
  assign mag_ay   = angle_y[AngleW-1] ? AngleW'(-angle_y) : AngleW'(angle_y);
  assign mode_new = scroll_mode ^ (!scroll_level && last_scroll);
  assign steps    = (mag_ax[16:11] > 6'd3) ? 2'd3 : mag_ax[12:11];

  always_ff @(posedge clk) begin
    if (rst) begin
      last_left   <= 1'b1;
      last_right  <= 1'b1;
      last_scroll <= 1'b1;
      scroll_mode <= 1'b0;
    end else if (accept) begin
      last_left   <= left_level;
      last_right  <= right_level;
      last_scroll <= scroll_level;
      scroll_mode <= mode_new;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      exc_x      <= (mag_ax > {1'b0, zone_half}) ? mag_ax - {1'b0, zone_half} : '0;
      exc_y      <= (mag_ay > {1'b0, zone_half}) ? mag_ay - {1'b0, zone_half} : '0;
      // Horizontal motion follows angle_y; vertical motion is minus angle_x.
      neg_x      <= angle_y[AngleW-1];
      neg_y      <= !angle_x[AngleW-1];
      hold_left  <= !left_level && last_left;
      hold_right <= !right_level && last_right;
      hold_scv   <= mode_new && (mag_ax > {1'b0, zone_half});
      if (mode_new && (mag_ax > {1'b0, zone_half})) begin
        hold_sa <= angle_x[AngleW-1] ? $signed({1'b0, steps}) : -$signed({1'b0, steps});
      end else begin
        hold_sa <= '0;
      end
    end
  end

  // ---------------- Sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (accept) state_next = ST_RAW_X;
      ST_RAW_X: state_next = ST_RAW_Y;
      ST_RAW_Y: state_next = ST_OLD_X;
      ST_OLD_X: state_next = ST_NEW_X;
      ST_NEW_X: state_next = ST_OLD_Y;
      ST_OLD_Y: state_next = ST_NEW_Y;
      ST_NEW_Y: state_next = ST_ACC_Y;
      ST_ACC_Y: state_next = ST_FIN_Y;
      ST_FIN_Y: state_next = ST_OUT;
      ST_OUT:   if (!out_valid || out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  assign weight_new = MulBW'(18'h10000 - {2'b00, smoothing});

  always_comb begin
    in_ready   = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    load_raw_x = 1'b0;
    load_raw_y = 1'b0;
    acc_load   = 1'b0;
    acc_add    = 1'b0;
    load_sx    = 1'b0;
    load_sy    = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_RAW_X: begin
        mul_a = $signed({8'd0, exc_y});
        mul_b = $signed({2'b00, gain});
      end
      ST_RAW_Y: begin
        mul_a      = $signed({8'd0, exc_x});
        mul_b      = $signed({2'b00, gain});
        load_raw_x = 1'b1;
      end
      ST_OLD_X: begin
        mul_a      = MulAW'(smooth_x);
        mul_b      = $signed({2'b00, smoothing});
        load_raw_y = 1'b1;
      end
      ST_NEW_X: begin
        mul_a    = MulAW'(raw_x);
        mul_b    = weight_new;
        acc_load = 1'b1;
      end
      ST_OLD_Y: begin
        mul_a   = MulAW'(smooth_y);
        mul_b   = $signed({2'b00, smoothing});
        acc_add = 1'b1;
      end
      ST_NEW_Y: begin
        mul_a    = MulAW'(raw_y);
        mul_b    = weight_new;
        load_sx  = 1'b1;
        acc_load = 1'b1;
      end
      ST_ACC_Y: acc_add = 1'b1;
      ST_FIN_Y: load_sy = 1'b1;
      ST_OUT:   out_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  // ---------------- Shared multiplier and accumulator ----------------
  assign prod_shr  = prod[32:4];
  assign lim       = {6'd0, speed_limit, 16'd0};
  assign raw_mag   = (prod_shr > lim) ? lim[22:0] : prod_shr[22:0];
  assign raw_pos   = $signed({1'b0, raw_mag});
  assign acc_trunc = trunc16(acc);

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (acc_load) begin
      acc <= prod;
    end else if (acc_add) begin
      acc <= acc + prod;
    end
    if (load_raw_x) begin
      raw_x <= neg_x ? -raw_pos : raw_pos;
    end
    if (load_raw_y) begin
      raw_y <= neg_y ? -raw_pos : raw_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      smooth_x <= '0;
      smooth_y <= '0;
    end else begin
      if (load_sx) begin
        smooth_x <= acc_trunc;
      end
      if (load_sy) begin
        smooth_y <= acc_trunc;
      end
    end
  end

  // ---------------- Result register ----------------
  assign abs_sx = smooth_x[SmoothW-1] ? SmoothW'(-smooth_x) : SmoothW'(smooth_x);
  assign abs_sy = smooth_y[SmoothW-1] ? SmoothW'(-smooth_y) : SmoothW'(smooth_y);
  assign thr    = {1'b0, move_threshold, 8'd0};
  assign mv     = (abs_sx > thr) || (abs_sy > thr);
  assign mag_mx = abs_sx[23:16];
  assign mag_my = abs_sy[23:16];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      move_valid     <= mv;
      move_x         <= !mv ? 8'sd0 : smooth_x[SmoothW-1] ? -$signed(mag_mx) : $signed(mag_mx);
      move_y         <= !mv ? 8'sd0 : smooth_y[SmoothW-1] ? -$signed(mag_my) : $signed(mag_my);
      left_click     <= hold_left;
      right_click    <= hold_right;
      scroll_valid   <= hold_scv;
      scroll_amount  <= hold_sa;
      scroll_mode_on <= scroll_mode;
    end
  end

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// Tilt pointer motion filter testbench
// Sends tilt and button frames as requests. A class predicts each frame's
// pointer, click and scroll report, and every returned report is compared
// with the oldest prediction. Runs directed frames, then random frames under
// several register settings; random stalls on both sides stop in the late frames.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import tpmf_pkg::*;

  localparam logic [2:0] RegSpareLo = 3'd5;
  localparam logic [2:0] RegSpareHi = 3'd7;
  localparam int IdleLimit = 2000;
  localparam int SettleCycles = 12;
  localparam int FramesPerPhase = 280;
  localparam int NumPhases = 7;

  typedef struct {
    logic              move_valid;
    logic signed [7:0] move_x;
    logic signed [7:0] move_y;
    logic              left_click;
    logic              right_click;
    logic              scroll_valid;
    logic signed [2:0] scroll_amount;
    logic              scroll_mode_on;
  } report_t;

  class pointer_report_model;
    int      zone_q8;
    int      gain_q12;
    int      speed_cap;
    int      keep_q16;
    int      move_floor;
    longint  track_x;
    longint  track_y;
    bit      prev_left;
    bit      prev_right;
    bit      prev_scroll;
    bit      scrolling;
    report_t pending_reports[$];
    int      failures;

    function new();
      zone_q8     = int'(DeadZoneRst);
      gain_q12    = int'(GainRst);
      speed_cap   = int'(MaxSpeedRst);
      keep_q16    = int'(SmoothingRst);
      move_floor  = int'(ThresholdRst);
      track_x     = 0;
      track_y     = 0;
      prev_left   = 1'b1;
      prev_right  = 1'b1;
      prev_scroll = 1'b1;
      scrolling   = 1'b0;
      failures    = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] value);
      case (idx)
        RegDeadZone:  zone_q8 = int'(value[15:0]);
        RegGain:      gain_q12 = int'(value[15:0]);
        RegMaxSpeed:  speed_cap = int'(value[6:0]);
        RegSmoothing: keep_q16 = int'(value[15:0]);
        RegThreshold: move_floor = int'(value[14:0]);
        default: ;
      endcase
    endfunction

    // Dead zone removal, gain and clamp; Q8.16 pixels with the angle's sign.
    function longint tilt_speed(longint angle);
      longint mag;
      longint prod;
      longint cap;
      mag = (angle < 0) ? -angle : angle;
      if (mag <= zone_q8) return 0;
      prod = ((mag - zone_q8) * gain_q12) >>> 4;
      cap = longint'(speed_cap) << 16;
      if (prod > cap) prod = cap;
      return (angle < 0) ? -prod : prod;
    endfunction

    function longint blend(longint prev, longint raw);
      longint num;
      num = longint'(keep_q16) * prev + longint'(65536 - keep_q16) * raw;
      return num / 65536;
    endfunction

    function void note_frame(angle_t ax, angle_t ay, bit lv, bit rv, bit sv);
      report_t want;
      longint ax_l;
      longint floor_q16;
      longint steps;
      ax_l = longint'(ax);
      track_x = blend(track_x, tilt_speed(longint'(ay)));
      track_y = blend(track_y, -tilt_speed(ax_l));
      floor_q16 = longint'(move_floor) << 8;
      want.move_valid = 1'b0;
      want.move_x = '0;
      want.move_y = '0;
      if ((track_x < 0 ? -track_x : track_x) > floor_q16 ||
          (track_y < 0 ? -track_y : track_y) > floor_q16) begin
        want.move_valid = 1'b1;
        want.move_x = 8'(track_x / 65536);
        want.move_y = 8'(track_y / 65536);
      end
      want.left_click = !lv && prev_left;
      want.right_click = !rv && prev_right;
      if (!sv && prev_scroll) scrolling = !scrolling;
      prev_left = lv;
      prev_right = rv;
      prev_scroll = sv;
      want.scroll_valid = 1'b0;
      want.scroll_amount = '0;
      if (scrolling && (ax_l < 0 ? -ax_l : ax_l) > zone_q8) begin
        steps = (ax_l < 0 ? -ax_l : ax_l) / 2048;
        if (steps > 3) steps = 3;
        want.scroll_valid = 1'b1;
        want.scroll_amount = 3'((ax_l < 0) ? steps : -steps);
      end
      want.scroll_mode_on = scrolling;
      pending_reports.push_back(want);
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        failures++;
      end
    endfunction

    function void check_report(report_t got);
      report_t want;
      if (pending_reports.size() == 0) begin
        $error("report returned with no frame outstanding");
        failures++;
        return;
      end
      want = pending_reports.pop_front();
      compare_field("move_valid", want.move_valid, got.move_valid);
      compare_field("move_x", want.move_x, got.move_x);
      compare_field("move_y", want.move_y, got.move_y);
      compare_field("left_click", want.left_click, got.left_click);
      compare_field("right_click", want.right_click, got.right_click);
      compare_field("scroll_valid", want.scroll_valid, got.scroll_valid);
      compare_field("scroll_amount", want.scroll_amount, got.scroll_amount);
      compare_field("scroll_mode_on", want.scroll_mode_on, got.scroll_mode_on);
    endfunction

    function int outstanding();
      return pending_reports.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  angle_t            angle_x = '0;
  angle_t            angle_y = '0;
  logic              left_level = 1'b1;
  logic              right_level = 1'b1;
  logic              scroll_level = 1'b1;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              move_valid;
  logic signed [7:0] move_x;
  logic signed [7:0] move_y;
  logic              left_click;
  logic              right_click;
  logic              scroll_valid;
  logic signed [2:0] scroll_amount;
  logic              scroll_mode_on;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [AddrW-1:0]  paddr = '0;
  logic [DataW-1:0]  pwdata = '0;
  logic [DataW-1:0]  prdata;
  logic              pready;

  pointer_report_model motion = new();

  int frames_sent = 0;
  int send_gap_pct = 13;
  int recv_gap_pct = 77;
  int quiet_cycles = 0;

  tilt_pointer_motion_filter i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .angle_x        (angle_x),
    .angle_y        (angle_y),
    .left_level     (left_level),
    .right_level    (right_level),
    .scroll_level   (scroll_level),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .move_valid     (move_valid),
    .move_x         (move_x),
    .move_y         (move_y),
    .left_click     (left_click),
    .right_click    (right_click),
    .scroll_valid   (scroll_valid),
    .scroll_amount  (scroll_amount),
    .scroll_mode_on (scroll_mode_on),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin : take_reports
    report_t got;
    if (!rst && out_valid && out_ready) begin
      got.move_valid = move_valid;
      got.move_x = move_x;
      got.move_y = move_y;
      got.left_click = left_click;
      got.right_click = right_click;
      got.scroll_valid = scroll_valid;
      got.scroll_amount = scroll_amount;
      got.scroll_mode_on = scroll_mode_on;
      motion.check_report(got);
    end
    out_ready <= ($urandom_range(99) >= recv_gap_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= IdleLimit) begin
        $display("tilt_pointer_motion_filter verification failed");
        $finish;
      end
    end
  end

  // Stall pattern follows the number of frames sent so far.
  task automatic update_stalls();
    if (frames_sent < 650) begin
      send_gap_pct = 13;
      recv_gap_pct = 77;
    end else if (frames_sent < 1300) begin
      send_gap_pct = 77;
      recv_gap_pct = 13;
    end else begin
      send_gap_pct = 0;
      recv_gap_pct = 0;
    end
  endtask

  // Returns just after the request is taken; valid stays high so that the
  // next call can either keep it up with a new frame or drop it.
  task automatic send_frame(int ax, int ay, bit lv, bit rv, bit sv);
    update_stalls();
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    angle_x <= angle_t'(ax);
    angle_y <= angle_t'(ay);
    left_level <= lv;
    right_level <= rv;
    scroll_level <= sv;
    do @(posedge clk); while (!in_ready);
    motion.note_frame(angle_t'(ax), angle_t'(ay), lv, rv, sv);
    frames_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (motion.outstanding() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    motion.write_reg(idx, value);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(int zone, int gain, int cap, int keep, int floor_q8);
    write_reg(RegDeadZone, zone);
    write_reg(RegGain, gain);
    write_reg(RegMaxSpeed, cap);
    write_reg(RegSmoothing, keep);
    write_reg(RegThreshold, floor_q8);
    // Spare indexes must leave every register alone.
    write_reg(RegSpareLo, $urandom);
    write_reg(RegSpareHi, $urandom);
  endtask

  function automatic int pick_angle(int zone);
    int mag;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: mag = $urandom_range(zone + 6000);
      6, 7:             mag = $urandom_range(46080);
      8:                return int'($urandom_range(131071)) - 65536;
      default:          mag = zone + int'($urandom_range(2)) - 1;
    endcase
    return $urandom_range(1) ? -mag : mag;
  endfunction

  task automatic random_frames(int count);
    for (int n = 0; n < count; n++) begin
      send_frame(pick_angle(motion.zone_q8), pick_angle(motion.zone_q8),
                 $urandom_range(3) != 0, $urandom_range(3) != 0,
                 $urandom_range(3) != 0);
      if ($urandom_range(149) == 0) wait_idle();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: dead zone edges, extremes, buttons and scroll mode.
    send_frame(0, 0, 1, 1, 1);
    send_frame(1280, -1280, 1, 1, 1);
    send_frame(1281, -1281, 0, 1, 1);
    send_frame(46080, 46080, 1, 0, 1);
    send_frame(-46080, -46080, 0, 0, 1);
    send_frame(-65536, 65535, 1, 1, 1);
    send_frame(65535, -65536, 1, 1, 0);
    send_frame(1281, 0, 1, 1, 1);
    send_frame(-4096, 0, 1, 1, 1);
    send_frame(16384, 0, 1, 1, 1);
    send_frame(1280, 0, 1, 1, 1);
    send_frame(-2047, 0, 1, 1, 1);
    send_frame(-46080, 46080, 1, 1, 1);
    send_frame(0, 0, 1, 1, 0);
    send_frame(-46080, 0, 1, 1, 1);
    send_frame(0, 0, 0, 0, 0);
    send_frame(0, 0, 0, 0, 0);
    send_frame(0, 0, 1, 1, 1);
    send_frame(0, 0, 1, 1, 1);
    send_frame(0, 0, 1, 1, 1);
    random_frames(FramesPerPhase);

    for (int phase = 1; phase < NumPhases; phase++) begin
      wait_idle();
      case (phase)
        1: apply_settings(0, 65535, 127, 0, 0);
        2: apply_settings(46080, 0, 0, 65535, 32767);
        3: apply_settings(0, 65535, 0, 32768, 0);
        default: apply_settings($urandom_range(3000), $urandom_range(65535),
                                $urandom_range(127), $urandom_range(65535),
                                $urandom_range(3000));
      endcase
      random_frames(FramesPerPhase);
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (motion.failures == 0) begin
      $display("tilt_pointer_motion_filter verification clean");
    end else begin
      $display("tilt_pointer_motion_filter verification failed");
    end
    $finish;
  end

endmodule
